/* rtl/record_slot_free_list_table_macros.svh */
// assertion macros for the record slot free list table
// used by the back-end module; no other dependencies
`ifndef RECORD_SLOT_FREE_LIST_TABLE_MACROS_SVH
`define RECORD_SLOT_FREE_LIST_TABLE_MACROS_SVH

// same-cycle implication, disabled during reset
`define RSFT_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// next-cycle implication, disabled during reset
`define RSFT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

/* rtl/rsft_pkg.sv */
// shared types, codes and defaults for the record slot free list table
// no dependencies
package rsft_pkg;

  // defaults for the top-level parameters
  localparam int SLOT_COUNT_DEF    = 1024;
  localparam int POSITION_BITS_DEF = 32;

  // fixed field widths
  localparam int CMD_W    = 3;
  localparam int SLOT_W   = 10;
  localparam int FE_W     = 32;
  localparam int SIZE_W   = 32;
  localparam int OUT_W    = 32;
  localparam int LCOUNT_W = 11;
  localparam int STATUS_W = 2;
  localparam int HDR_W    = 7;
  // file end plus header length never overflows this
  localparam int SUM_W    = FE_W + 1;

  localparam logic [HDR_W-1:0] HEADER_BYTES_RESET = 7'd16;

  // command codes on the input
  localparam logic [CMD_W-1:0] CMD_ALLOC  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SET    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

  // classified operations in the queue
  localparam logic [CMD_W-1:0] OP_ALLOC  = 3'd0;
  localparam logic [CMD_W-1:0] OP_REMOVE = 3'd1;
  localparam logic [CMD_W-1:0] OP_SET    = 3'd2;
  localparam logic [CMD_W-1:0] OP_LOOKUP = 3'd3;
  localparam logic [CMD_W-1:0] OP_CLEAR  = 3'd4;
  localparam logic [CMD_W-1:0] OP_NONE   = 3'd5;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [SLOT_W-1:0] slot;
    logic [FE_W-1:0]   file_end;
    logic [SIZE_W-1:0] new_size;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0]   slot_out;
    logic [OUT_W-1:0]    data_position;
    logic [SIZE_W-1:0]   record_size;
    logic [OUT_W-1:0]    header_position;
    logic                live;
    logic [LCOUNT_W-1:0] live_count;
    logic [STATUS_W-1:0] status;
  } out_item_t;

  // one classified command waiting for the back end
  typedef struct packed {
    logic [CMD_W-1:0]  op;
    logic [SLOT_W-1:0] slot;
    logic [FE_W-1:0]   file_end;
    logic [SUM_W-1:0]  alloc_sum;
    logic [SIZE_W-1:0] new_size;
  } qent_t;

endpackage

/* rtl/rsft_ram.sv */
// generic simple dual-port ram with registered read
// no dependencies
module rsft_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/rsft_front.sv */
// front end: takes commands, classifies them and queues them for the back end
// depends on rsft_pkg
module rsft_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  rsft_pkg::in_item_t        in_data,
  input  logic [rsft_pkg::HDR_W-1:0] header_bytes,
  output logic                      q_valid,
  output rsft_pkg::qent_t           q_entry,
  input  logic                      q_pop
);

  import rsft_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  qent_t             entry [QUEUE_DEPTH];
  qent_t             classified;
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  fill;
  logic              push;

  // classify the command and form the allocation position
  always_comb begin
    classified          = '0;
    classified.slot     = in_data.slot;
    classified.file_end = in_data.file_end;
    classified.new_size = in_data.new_size;
    classified.alloc_sum = SUM_W'(in_data.file_end) + SUM_W'(header_bytes);
    case (in_data.command)
      CMD_ALLOC:  classified.op = OP_ALLOC;
      CMD_REMOVE: classified.op = OP_REMOVE;
      CMD_SET:    classified.op = OP_SET;
      CMD_LOOKUP: classified.op = OP_LOOKUP;
      CMD_CLEAR:  classified.op = OP_CLEAR;
      default:    classified.op = OP_NONE;
    endcase
  end

  assign in_ready = (fill != CNT_W'(QUEUE_DEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (fill != '0);
  assign q_entry  = entry[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= classified;
    end
  end

  // queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(wr_ptr + 1'b1);
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(rd_ptr + 1'b1);
      end
      if (push && !q_pop) begin
        fill <= CNT_W'(fill + 1'b1);
      end else if (q_pop && !push) begin
        fill <= CNT_W'(fill - 1'b1);
      end
    end
  end

endmodule

/* rtl/rsft_back.sv */
// back end: slot table memories, free list and result register
// depends on rsft_pkg, rsft_ram and the assertion macro header
`include "record_slot_free_list_table_macros.svh"

module rsft_back #(
  parameter int SLOT_COUNT    = rsft_pkg::SLOT_COUNT_DEF,
  parameter int POSITION_BITS = rsft_pkg::POSITION_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [rsft_pkg::HDR_W-1:0] header_bytes,
  input  logic                       q_valid,
  input  rsft_pkg::qent_t            q_entry,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output rsft_pkg::out_item_t        out_data
);

  import rsft_pkg::*;

  localparam int PW = POSITION_BITS;
  localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CW = $clog2(SLOT_COUNT + 1);
  // position memory also carries free-list links
  localparam int MW = (PW > CW) ? PW : CW;

  localparam logic [CW-1:0] NO_SLOT = CW'(SLOT_COUNT);

  // sequencer codes
  localparam logic S_IDLE = 1'b0;
  localparam logic S_RUN  = 1'b1;

  logic            state;
  qent_t           work;
  logic [CW-1:0]   free_head;
  logic [CW-1:0]   free_head_next;
  logic [CW-1:0]   table_length;
  logic [CW-1:0]   table_length_next;
  logic [CW-1:0]   count_live;
  logic [CW-1:0]   count_live_next;
  out_item_t       result;

  logic [IW-1:0]   rd_addr;
  logic [IW-1:0]   wr_addr;
  logic [IW-1:0]   k;
  logic [MW-1:0]   rd_pos;
  logic [SIZE_W-1:0] rd_size;
  logic            rd_live;
  logic            pos_we;
  logic            size_we;
  logic            live_we;
  logic            mem_we;
  logic [MW-1:0]   pos_wd;
  logic [SIZE_W-1:0] size_wd;
  logic            live_wd;
  logic            in_len;
  logic            ok;
  logic            grant;
  logic [PW-1:0]   pos_new;
  logic [PW-1:0]   pos_cur;
  logic [PW-1:0]   hdr_cur;

  // pop when idle and the result register is free by the next load
  assign q_pop   = (state == S_IDLE) && q_valid && (!out_valid || out_ready);
  assign rd_addr = (q_entry.op == OP_ALLOC) ? IW'(free_head) : IW'(q_entry.slot);
  assign mem_we  = (state == S_RUN);
  assign k       = IW'(work.slot);

  // slot table memories
  rsft_ram #(.WIDTH(MW), .DEPTH(SLOT_COUNT)) u_pos_ram (
    .clk   (clk),
    .we    (mem_we && pos_we),
    .waddr (wr_addr),
    .wdata (pos_wd),
    .re    (q_pop),
    .raddr (rd_addr),
    .rdata (rd_pos)
  );

  rsft_ram #(.WIDTH(SIZE_W), .DEPTH(SLOT_COUNT)) u_size_ram (
    .clk   (clk),
    .we    (mem_we && size_we),
    .waddr (wr_addr),
    .wdata (size_wd),
    .re    (q_pop),
    .raddr (rd_addr),
    .rdata (rd_size)
  );

  rsft_ram #(.WIDTH(1), .DEPTH(SLOT_COUNT)) u_live_ram (
    .clk   (clk),
    .we    (mem_we && live_we),
    .waddr (wr_addr),
    .wdata (live_wd),
    .re    (q_pop),
    .raddr (rd_addr),
    .rdata (rd_live)
  );

  // execute the command with the read data
  always_comb begin
    free_head_next    = free_head;
    table_length_next = table_length;
    count_live_next   = count_live;
    result            = '0;
    wr_addr           = k;
    pos_we            = 1'b0;
    size_we           = 1'b0;
    live_we           = 1'b0;
    pos_wd            = '0;
    size_wd           = '0;
    live_wd           = 1'b0;
    grant             = 1'b0;
    in_len            = 32'(work.slot) < 32'(table_length);
    ok                = in_len && rd_live;
    pos_new           = PW'(work.alloc_sum);
    pos_cur           = PW'(rd_pos);
    hdr_cur           = PW'(pos_cur - PW'(header_bytes));
    case (work.op)
      OP_ALLOC: begin
        if (free_head < NO_SLOT) begin
          wr_addr        = IW'(free_head);
          free_head_next = (rd_pos > MW'(SLOT_COUNT)) ? NO_SLOT : CW'(rd_pos);
          grant          = 1'b1;
        end else if (table_length < NO_SLOT) begin
          wr_addr           = IW'(table_length);
          table_length_next = CW'(table_length + 1'b1);
          grant             = 1'b1;
        end else begin
          result.status = ST_FULL;
        end
        if (grant) begin
          pos_we                 = 1'b1;
          size_we                = 1'b1;
          live_we                = 1'b1;
          pos_wd                 = MW'(pos_new);
          live_wd                = 1'b1;
          count_live_next        = CW'(count_live + 1'b1);
          result.slot_out        = SLOT_W'(wr_addr);
          result.data_position   = OUT_W'(pos_new);
          result.header_position = OUT_W'(PW'(work.file_end));
          result.live            = 1'b1;
        end
      end
      OP_REMOVE: begin
        result.slot_out = work.slot;
        if (ok) begin
          pos_we          = 1'b1;
          size_we         = 1'b1;
          live_we         = 1'b1;
          pos_wd          = MW'(free_head);
          free_head_next  = CW'(k);
          count_live_next = CW'(count_live - 1'b1);
        end else begin
          result.status = ST_BAD;
        end
      end
      OP_SET, OP_LOOKUP: begin
        result.slot_out = work.slot;
        if (ok) begin
          if (work.op == OP_SET) begin
            size_we            = 1'b1;
            size_wd            = work.new_size;
            result.record_size = work.new_size;
          end else begin
            result.record_size = rd_size;
          end
          result.data_position   = OUT_W'(pos_cur);
          result.header_position = OUT_W'(hdr_cur);
          result.live            = 1'b1;
        end else begin
          result.status = ST_BAD;
        end
      end
      OP_CLEAR: begin
        free_head_next    = NO_SLOT;
        table_length_next = '0;
        count_live_next   = '0;
      end
      default: begin
      end
    endcase
    result.live_count = LCOUNT_W'(count_live_next);
  end

  // sequencer and table state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      free_head    <= NO_SLOT;
      table_length <= '0;
      count_live   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (q_pop) begin
            state <= S_RUN;
          end
        end
        S_RUN: begin
          state        <= S_IDLE;
          free_head    <= free_head_next;
          table_length <= table_length_next;
          count_live   <= count_live_next;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // command being worked on
  always_ff @(posedge clk) begin
    if (q_pop) begin
      work <= q_entry;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_RUN) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RUN) begin
      out_data <= result;
    end
  end

  // checks
  `RSFT_ASSERT_NOW(a_live_le_len, clk, rst, 1'b1, count_live <= table_length)
  `RSFT_ASSERT_NOW(a_len_in_range, clk, rst, 1'b1, table_length <= NO_SLOT)
  `RSFT_ASSERT_NOW(a_head_in_range, clk, rst, 1'b1, free_head <= NO_SLOT)
  `RSFT_ASSERT_NOW(a_result_free, clk, rst, state == S_RUN, !out_valid)
  `RSFT_ASSERT_NEXT(a_pop_runs, clk, rst, q_pop, state == S_RUN && out_valid == 1'b0)

endmodule

/* rtl/record_slot_free_list_table.sv */
// top level of the record slot free list table
// depends on rsft_pkg, rsft_front and rsft_back
//
//   channel  direction  handshake            payload
//   in       input      in_valid/in_ready    in_item_t command
//   out      output     out_valid/out_ready  out_item_t result
//   cfg      input      cfg_we               cfg_wdata, header length
//
// in the back end each command does one slot memory read, then the update and
// memory write before the next command is taken; this read-then-write sets the rate
// the front queue holds two commands and keeps taking them while a result waits
// reset is synchronous; table, free list and live count are empty after it
// no memory clearing pass: entries are written before they are ever read
// a stalled result holds the back end; the queue then fills and in_ready falls
module record_slot_free_list_table #(
  parameter int SLOT_COUNT    = rsft_pkg::SLOT_COUNT_DEF,
  parameter int POSITION_BITS = rsft_pkg::POSITION_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  rsft_pkg::in_item_t         in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output rsft_pkg::out_item_t        out_data,
  input  logic                       cfg_we,
  input  logic [rsft_pkg::HDR_W-1:0] cfg_wdata
);

  import rsft_pkg::*;

  logic [HDR_W-1:0] header_bytes;
  logic             q_valid;
  logic             q_pop;
  qent_t            q_entry;

  // header length register
  always_ff @(posedge clk) begin
    if (rst) begin
      header_bytes <= HEADER_BYTES_RESET;
    end else if (cfg_we) begin
      header_bytes <= cfg_wdata;
    end
  end

  rsft_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .header_bytes (header_bytes),
    .q_valid      (q_valid),
    .q_entry      (q_entry),
    .q_pop        (q_pop)
  );

  rsft_back #(
    .SLOT_COUNT    (SLOT_COUNT),
    .POSITION_BITS (POSITION_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .header_bytes (header_bytes),
    .q_valid      (q_valid),
    .q_entry      (q_entry),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data)
  );

endmodule
